>>> sv/mifd_pkg.sv
// Shared types, constants and codes for the modem IPC frame deframer.
package mifd_pkg;

    // Frame flags.
    localparam logic [7:0] START_FLAG = 8'h7F;
    localparam logic [7:0] END_FLAG   = 8'h7E;

    // Largest payload chunk in bytes, and the width of the chunk fill counter.
    localparam int CHUNK_BYTES = 3584;
    localparam int FILL_W      = 12;

    // Header sizes and the header byte counter.
    localparam int          HDR_MAX   = 6;
    localparam int          CNT_W     = 3;
    localparam logic [2:0]  HDR_SHORT = 3'd3;
    localparam logic [2:0]  HDR_LONG  = 3'd6;

    // Frame format register codes.
    localparam logic [1:0] FMT_FMT   = 2'd0;
    localparam logic [1:0] FMT_RAW   = 2'd1;
    localparam logic [1:0] FMT_MULTI = 2'd2;
    localparam logic [1:0] FMT_RFS   = 2'd3;

    // Register map.
    localparam int         PADDR_W          = 2;
    localparam logic [1:0] ADDR_FRAME_FORMAT = 2'd0;

    // Result kinds.
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Error codes.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_START = 3'd1;
    localparam logic [2:0] ERR_BAD_END   = 3'd2;
    localparam logic [2:0] ERR_TOO_LARGE = 3'd3;
    localparam logic [2:0] ERR_LEN_SHORT = 3'd4;

    // Deframer phase, one-hot.
    typedef enum logic [4:0] {
        PH_WAIT    = 5'b00001,
        PH_HEADER  = 5'b00010,
        PH_PAYLOAD = 5'b00100,
        PH_END     = 5'b01000,
        PH_DROP    = 5'b10000
    } phase_t;

    // One link beat.
    typedef struct packed {
        logic [7:0] link_byte;
        logic       buffer_last;
    } in_beat_t;

    // One result beat.
    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] payload_byte;
        logic       chunk_last;
        logic [7:0] frame_channel;
        logic [2:0] error_code;
    } out_beat_t;

    // Result handed from the core to the output buffer.
    typedef struct packed {
        logic      push;
        out_beat_t beat;
    } res_push_t;

endpackage

>>> sv/mifd_cfg.sv
// Configuration register block with its APB-style access port.
module mifd_cfg
    import mifd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [1:0]         frame_format
);

    logic [1:0] frame_format_reg;
    logic       wr_en;

    // Write strobe on the access cycle of a write.
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_FRAME_FORMAT);
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_format_reg <= FMT_FMT;
        end
        else if (wr_en)
        begin
            frame_format_reg <= pwdata[1:0];
        end
    end

    // Read back.
    always_comb
    begin
        prdata = 32'd0;
        if (paddr == ADDR_FRAME_FORMAT)
        begin
            prdata = {30'd0, frame_format_reg};
        end
    end

    assign frame_format = frame_format_reg;

endmodule

>>> sv/mifd_core.sv
// Input register, deframing state and per-byte result logic.
module mifd_core
    import mifd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] frame_format,
    input  logic       link_valid,
    output logic       link_stall,
    input  in_beat_t   link_data,
    input  logic       obuf_full,
    output res_push_t  res
);

    // Input stage.
    logic     s1_vld_reg;
    in_beat_t s1_beat_reg;
    logic     s1_fire;
    logic     accept;

    // Frame state.
    phase_t                 phase_reg, phase_next;
    logic [7:0]             hb_reg [HDR_MAX];
    logic [7:0]             hb_next [HDR_MAX];
    logic [CNT_W-1:0]       header_count_reg, header_count_next;
    logic [31:0]            rem_reg, rem_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;

    // Per-byte working signals.
    logic [7:0]             b;
    logic                   buf_last;
    logic                   rfs;
    logic [2:0]             hdr_size;
    logic                   count_inc;
    logic [CNT_W-1:0]       count_new;
    logic [7:0]             hb_new [HDR_MAX];
    logic                   hdr_done;
    logic [31:0]            len;
    logic                   len_short;
    logic [31:0]            data_len;
    logic                   too_large;
    logic [7:0]             chan_cur;
    logic [7:0]             chan_hdr;
    logic [FILL_W:0]        fill_inc;
    logic                   fill_wrap;
    logic [31:0]            rem_dec;
    logic                   rem_zero;
    logic                   do_clear;
    logic                   do_emit;
    logic                   emit_more;
    logic [7:0]             emit_chan;
    out_beat_t              beat;
    logic                   push;

    // The input register moves on whenever the output buffer has room.
    assign s1_fire    = s1_vld_reg && !obuf_full;
    assign link_stall = s1_vld_reg && obuf_full;
    assign accept     = link_valid && !link_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_vld_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_beat_reg <= link_data;
        end
    end

    assign b        = s1_beat_reg.link_byte;
    assign buf_last = s1_beat_reg.buffer_last;
    assign rfs      = (frame_format == FMT_RFS);
    assign hdr_size = (frame_format == FMT_FMT) ? HDR_SHORT : HDR_LONG;

    // Header capture: the byte lands at the current count while room remains.
    assign count_inc = (header_count_reg < CNT_W'(HDR_MAX));
    assign count_new = header_count_reg + CNT_W'(count_inc);

    always_comb
    begin
        for (int i = 0; i < HDR_MAX; i++)
        begin
            hb_new[i] = (count_inc && header_count_reg == CNT_W'(i)) ? b : hb_reg[i];
        end
    end

    assign hdr_done = (count_new >= hdr_size);

    // Little-endian length; 16 bits in the short header, 32 in the long one.
    assign len = (frame_format == FMT_FMT) ? {16'd0, hb_new[1], hb_new[0]}
                                           : {hb_new[3], hb_new[2], hb_new[1], hb_new[0]};
    assign len_short = (len < {29'd0, hdr_size});
    assign data_len  = len - {29'd0, hdr_size};
    assign too_large = (frame_format == FMT_MULTI) && (data_len > 32'(CHUNK_BYTES));

    // Channel byte: the stored one, or the one just captured at header end.
    assign chan_cur = (frame_format != FMT_FMT) ? hb_reg[4] : 8'd0;
    assign chan_hdr = (frame_format != FMT_FMT) ? hb_new[4] : 8'd0;

    // Chunk fill counter for an emitted byte.
    assign fill_inc  = {1'b0, fill_reg} + (FILL_W+1)'(1);
    assign fill_wrap = (fill_inc >= (FILL_W+1)'(CHUNK_BYTES));

    // Payload countdown.
    assign rem_dec  = (rem_reg != 32'd0) ? rem_reg - 32'd1 : rem_reg;
    assign rem_zero = (rem_dec == 32'd0);

    // Phase decode and result selection.
    always_comb
    begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        rem_next          = rem_reg;
        fill_next         = fill_reg;
        for (int i = 0; i < HDR_MAX; i++)
        begin
            hb_next[i] = hb_reg[i];
        end
        do_clear  = 1'b0;
        do_emit   = 1'b0;
        emit_more = 1'b0;
        emit_chan = 8'd0;
        push      = 1'b0;
        beat      = '0;

        case (phase_reg)
            PH_WAIT:
            begin
                do_clear = 1'b1;
                if (b != START_FLAG)
                begin
                    phase_next       = buf_last ? PH_WAIT : PH_DROP;
                    push             = 1'b1;
                    beat.result_kind = KIND_ERROR;
                    beat.error_code  = ERR_BAD_START;
                end
                else
                begin
                    phase_next = PH_HEADER;
                end
            end
            PH_HEADER:
            begin
                header_count_next = count_new;
                for (int i = 0; i < HDR_MAX; i++)
                begin
                    hb_next[i] = hb_new[i];
                end
                if (!hdr_done)
                begin
                    do_emit   = rfs;
                    emit_more = 1'b1;
                end
                else if (len_short || too_large)
                begin
                    do_clear           = 1'b1;
                    phase_next         = buf_last ? PH_WAIT : PH_DROP;
                    push               = 1'b1;
                    beat.result_kind   = KIND_ERROR;
                    beat.frame_channel = chan_hdr;
                    beat.error_code    = len_short ? ERR_LEN_SHORT : ERR_TOO_LARGE;
                end
                else
                begin
                    rem_next   = data_len;
                    phase_next = (data_len != 32'd0) ? PH_PAYLOAD : PH_END;
                    do_emit    = rfs;
                    emit_more  = (data_len != 32'd0);
                    emit_chan  = chan_hdr;
                end
            end
            PH_PAYLOAD:
            begin
                rem_next = rem_dec;
                if (rem_zero)
                begin
                    phase_next = PH_END;
                end
                do_emit   = 1'b1;
                emit_more = !rem_zero;
                emit_chan = chan_cur;
            end
            PH_END:
            begin
                do_clear           = 1'b1;
                push               = 1'b1;
                beat.frame_channel = chan_cur;
                if (b != END_FLAG)
                begin
                    phase_next       = buf_last ? PH_WAIT : PH_DROP;
                    beat.result_kind = KIND_ERROR;
                    beat.error_code  = ERR_BAD_END;
                end
                else
                begin
                    phase_next       = PH_WAIT;
                    beat.result_kind = KIND_DONE;
                end
            end
            PH_DROP:
            begin
                if (buf_last)
                begin
                    phase_next = PH_WAIT;
                end
            end
            default:
            begin
                phase_next = PH_WAIT;
            end
        endcase

        // Payload byte out, with chunk accounting.
        if (do_emit)
        begin
            push               = 1'b1;
            beat.result_kind   = KIND_PAYLOAD;
            beat.payload_byte  = b;
            beat.chunk_last    = fill_wrap && emit_more;
            beat.frame_channel = emit_chan;
            fill_next          = fill_wrap ? '0 : fill_inc[FILL_W-1:0];
        end

        // Frame start, end and every error leave a clean frame state.
        if (do_clear)
        begin
            header_count_next = '0;
            rem_next          = 32'd0;
            fill_next         = '0;
            for (int i = 0; i < HDR_MAX; i++)
            begin
                hb_next[i] = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_WAIT;
            header_count_reg <= '0;
            rem_reg          <= 32'd0;
            fill_reg         <= '0;
            for (int i = 0; i < HDR_MAX; i++)
            begin
                hb_reg[i] <= 8'd0;
            end
        end
        else if (s1_fire)
        begin
            phase_reg        <= phase_next;
            header_count_reg <= header_count_next;
            rem_reg          <= rem_next;
            fill_reg         <= fill_next;
            for (int i = 0; i < HDR_MAX; i++)
            begin
                hb_reg[i] <= hb_next[i];
            end
        end
    end

    assign res.push = s1_fire && push;
    assign res.beat = beat;

    // The payload phase always has bytes left to take.
    a_payload_rem: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> rem_reg != 32'd0)
        else $error("payload phase with no bytes remaining");

    // Outside a frame the frame state is clean.
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WAIT || phase_reg == PH_DROP) |->
            (header_count_reg == '0 && rem_reg == 32'd0 && fill_reg == '0))
        else $error("frame state not cleared outside a frame");

    // The chunk fill counter never reaches a full chunk.
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < FILL_W'(CHUNK_BYTES))
        else $error("chunk fill counter out of range");

    // An error on a byte that does not end the buffer starts dropping.
    a_drop_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        (res.push && res.beat.result_kind == KIND_ERROR && !buf_last) |=>
            phase_reg == PH_DROP)
        else $error("error did not enter the drop phase");

endmodule

>>> sv/mifd_obuf.sv
// Two-entry result buffer that decouples the core from the result channel.
module mifd_obuf
    import mifd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  res_push_t res,
    output logic      obuf_full,
    output logic      result_valid,
    input  logic      result_stall,
    output out_beat_t result_data
);

    out_beat_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign pop          = result_valid && !result_stall;
    assign result_valid = (count_reg != 2'd0);
    assign obuf_full    = (count_reg == 2'd2);
    assign result_data  = entry_reg[rd_ptr_reg];

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (res.push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(res.push) - 2'(pop);
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (res.push)
        begin
            entry_reg[wr_ptr_reg] <= res.beat;
        end
    end

    // No push into a full buffer.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res.push |-> count_reg != 2'd2)
        else $error("result buffer overflow");

    // Occupancy matches the pointer distance.
    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[0] == (wr_ptr_reg ^ rd_ptr_reg))
        else $error("result buffer pointers and count disagree");

    // A waiting result stays until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("stalled result dropped");

endmodule

>>> sv/modem_ipc_frame_deframer.sv
// Top level of the modem IPC frame deframer.
//
// Link bytes enter on the link channel, one beat per byte, with buffer_last
// marking the final byte of a link buffer. Each accepted beat yields zero or
// one result beat: a payload byte, a frame-done marker or a frame error.
// Frames are 0x7F, a 3- or 6-byte header carrying the total length, payload
// and 0x7E; frame_format selects the header layout and is to be written
// through the APB port only while idle; the block does not enforce this.
//
// An accepted byte is captured in the input register and decoded from
// there; its result is written into the result buffer, which offers it on
// the result channel. One byte is taken every cycle unless link_stall is
// raised; the rate is set by the single decode stage, which updates the
// frame state once per byte.
//
// Reset clears the frame state, waits for a start flag and sets
// frame_format to the 3-byte header format. A two-entry result buffer holds
// results while the receiver stalls; once it is full and the decode stage
// holds a byte, link_stall rises until a result is taken.
module modem_ipc_frame_deframer
    import mifd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               link_valid,
    output logic               link_stall,
    input  in_beat_t           link_data,
    output logic               result_valid,
    input  logic               result_stall,
    output out_beat_t          result_data
);

    logic [1:0] frame_format;
    logic       obuf_full;
    res_push_t  res;

    mifd_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .frame_format (frame_format)
    );

    mifd_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_format (frame_format),
        .link_valid   (link_valid),
        .link_stall   (link_stall),
        .link_data    (link_data),
        .obuf_full    (obuf_full),
        .res          (res)
    );

    mifd_obuf u_obuf (
        .clk          (clk),
        .rst_n        (rst_n),
        .res          (res),
        .obuf_full    (obuf_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

>>> tb/tb_modem_ipc_frame_deframer.sv
// Self-checking testbench for the modem IPC frame deframer, with its scoreboard class.
import mifd_pkg::*;

// Tracks the deframer's frame state and holds the result beats it should produce.
class deframer_scoreboard;
    out_beat_t   expected_results[$];
    logic [1:0]  fmt;
    phase_t      phase;
    logic [7:0]  hdr[HDR_MAX];
    int unsigned hcnt;
    logic [31:0] remaining;
    int unsigned fill;
    int unsigned errors;
    int unsigned beats_seen;
    int unsigned payload_seen;
    int unsigned chunk_ends_seen;
    int unsigned frames_done;
    int unsigned frame_errors;

    function new();
        fmt = FMT_FMT;
        phase = PH_WAIT;
        errors = 0;
        beats_seen = 0;
        payload_seen = 0;
        chunk_ends_seen = 0;
        frames_done = 0;
        frame_errors = 0;
        clear_frame();
    endfunction

    function void set_format(logic [1:0] value);
        fmt = value;
    endfunction

    function int unsigned pending();
        return expected_results.size();
    endfunction

    function void clear_frame();
        foreach (hdr[i])
            hdr[i] = 8'd0;
        hcnt = 0;
        remaining = 32'd0;
        fill = 0;
    endfunction

    function logic [7:0] channel_now();
        return (fmt != FMT_FMT) ? hdr[4] : 8'd0;
    endfunction

    function void push_result(logic [1:0] kind, logic [7:0] data, logic last,
                              logic [7:0] chan, logic [2:0] code);
        out_beat_t r;
        r.result_kind   = kind;
        r.payload_byte  = data;
        r.chunk_last    = last;
        r.frame_channel = chan;
        r.error_code    = code;
        expected_results.push_back(r);
    endfunction

    // Any error clears the frame and drops the rest of the buffer.
    function void raise_error(logic [2:0] code, logic [7:0] chan, logic buf_last);
        clear_frame();
        phase = buf_last ? PH_WAIT : PH_DROP;
        push_result(KIND_ERROR, 8'd0, 1'b0, chan, code);
    endfunction

    // A payload byte; the chunk end is only flagged while payload remains.
    function void emit_payload(logic [7:0] data, logic more, logic [7:0] chan);
        logic last;
        last = 1'b0;
        fill++;
        if (fill >= CHUNK_BYTES)
        begin
            last = more;
            fill = 0;
        end
        push_result(KIND_PAYLOAD, data, last, chan, ERR_NONE);
    endfunction

    // Advance the frame state by one accepted link beat.
    function void predict_link_byte(in_beat_t beat);
        logic [7:0]  v;
        logic        buf_last;
        logic        rfs;
        int unsigned size;
        logic [7:0]  chan;
        logic [31:0] len;
        logic [31:0] data;
        v = beat.link_byte;
        buf_last = beat.buffer_last;
        rfs = (fmt == FMT_RFS);
        beats_seen++;
        case (phase)
            PH_WAIT:
            begin
                if (v != START_FLAG)
                    raise_error(ERR_BAD_START, 8'd0, buf_last);
                else
                begin
                    clear_frame();
                    phase = PH_HEADER;
                end
            end
            PH_HEADER:
            begin
                if (hcnt < HDR_MAX)
                begin
                    hdr[hcnt] = v;
                    hcnt++;
                end
                size = (fmt == FMT_FMT) ? HDR_SHORT : HDR_LONG;
                if (hcnt < size)
                begin
                    if (rfs)
                        emit_payload(v, 1'b1, 8'd0);
                end
                else
                begin
                    chan = channel_now();
                    if (fmt == FMT_FMT)
                        len = {16'd0, hdr[1], hdr[0]};
                    else
                        len = {hdr[3], hdr[2], hdr[1], hdr[0]};
                    if (len < size)
                        raise_error(ERR_LEN_SHORT, chan, buf_last);
                    else
                    begin
                        data = len - size;
                        if (fmt == FMT_MULTI && data > CHUNK_BYTES)
                            raise_error(ERR_TOO_LARGE, chan, buf_last);
                        else
                        begin
                            remaining = data;
                            phase = (data != 0) ? PH_PAYLOAD : PH_END;
                            if (rfs)
                                emit_payload(v, data != 0, chan);
                        end
                    end
                end
            end
            PH_PAYLOAD:
            begin
                chan = channel_now();
                if (remaining != 0)
                    remaining--;
                if (remaining == 0)
                    phase = PH_END;
                emit_payload(v, remaining != 0, chan);
            end
            PH_END:
            begin
                chan = channel_now();
                if (v != END_FLAG)
                    raise_error(ERR_BAD_END, chan, buf_last);
                else
                begin
                    clear_frame();
                    phase = PH_WAIT;
                    push_result(KIND_DONE, 8'd0, 1'b0, chan, ERR_NONE);
                end
            end
            PH_DROP:
            begin
                if (buf_last)
                    phase = PH_WAIT;
            end
            default:
                phase = PH_WAIT;
        endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    // Compare one accepted result beat with the oldest expected one.
    function void check_result(out_beat_t got);
        out_beat_t want;
        if (expected_results.size() == 0)
        begin
            $error("result beat with nothing expected: kind %0d byte 0x%0h",
                   got.result_kind, got.payload_byte);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        compare_field("result_kind", want.result_kind, got.result_kind);
        compare_field("payload_byte", want.payload_byte, got.payload_byte);
        compare_field("chunk_last", want.chunk_last, got.chunk_last);
        compare_field("frame_channel", want.frame_channel, got.frame_channel);
        compare_field("error_code", want.error_code, got.error_code);
        case (want.result_kind)
            KIND_PAYLOAD:
            begin
                payload_seen++;
                if (want.chunk_last)
                    chunk_ends_seen++;
            end
            KIND_DONE:
                frames_done++;
            default:
                frame_errors++;
        endcase
    endfunction
endclass

module tb_modem_ipc_frame_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 6;
    localparam int SEGMENT_ITEMS = 85;
    localparam int HOLD_CYCLES   = 300;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               link_valid;
    logic               link_stall;
    in_beat_t           link_data;
    logic               result_valid;
    logic               result_stall;
    out_beat_t          result_data;

    deframer_scoreboard sb;
    int unsigned        link_items;
    int unsigned        send_idle_pct;
    int unsigned        stall_pct;
    int unsigned        hold_len;
    logic               hold_go;

    modem_ipc_frame_deframer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .link_valid   (link_valid),
        .link_stall   (link_stall),
        .link_data    (link_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        int unsigned left;
        logic        seen_go;
        left = 0;
        seen_go = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go != seen_go)
            begin
                seen_go = hold_go;
                left = hold_len;
            end
            if (left > 0)
            begin
                result_stall = 1'b1;
                left--;
            end
            else
                result_stall = ($urandom_range(99) < stall_pct);
        end
    end

    // Monitor: check result beats and feed accepted link beats to the predictor.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_result(result_data);
            if (link_valid && !link_stall)
                sb.predict_link_byte(link_data);
        end
    end

    // Offer one link beat, after a random idle gap, and wait until it is taken.
    task automatic send_link(logic [7:0] v, logic last);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            link_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        link_valid = 1'b1;
        link_data.link_byte = v;
        link_data.buffer_last = last;
        do
            @(posedge clk);
        while (link_stall);
        @(negedge clk);
    endtask

    // A counted beat with a random buffer boundary.
    task automatic send_byte(logic [7:0] v);
        link_items++;
        send_link(v, $urandom_range(7) == 0);
    endtask

    // Stop offering beats and wait for every expected result, plus a margin.
    task automatic drain_results();
        link_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_access(logic wr, logic [31:0] wdata);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = wr;
        paddr = ADDR_FRAME_FORMAT;
        pwdata = wdata;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (!wr && prdata !== wdata)
        begin
            $error("frame_format readback: expected 0x%0h, got 0x%0h", wdata, prdata);
            sb.errors++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Write the format register, read it back and update the predictor.
    task automatic write_format(logic [1:0] value);
        apb_access(1'b1, {30'd0, value});
        apb_access(1'b0, {30'd0, value});
        sb.set_format(value);
    endtask

    task automatic send_header(logic [31:0] len);
        if (sb.fmt == FMT_FMT)
        begin
            send_byte(len[7:0]);
            send_byte(len[15:8]);
            send_byte(8'($urandom_range(255)));
        end
        else
        begin
            for (int i = 0; i < 4; i++)
                send_byte(len[8*i +: 8]);
            send_byte(8'($urandom_range(255)));
            send_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic send_frame(int unsigned data_len, logic [7:0] end_byte);
        int unsigned hsize;
        hsize = (sb.fmt == FMT_FMT) ? HDR_SHORT : HDR_LONG;
        send_byte(START_FLAG);
        send_header(data_len + hsize);
        repeat (data_len) send_byte(8'($urandom_range(255)));
        send_byte(end_byte);
    endtask

    // Mostly short payloads, now and then a longer one.
    function automatic int unsigned random_payload_len();
        if ($urandom_range(9) == 0)
            return $urandom_range(100, 25);
        return $urandom_range(24);
    endfunction

    // After a broken sequence, skip bytes until the deframer waits for a start flag.
    task automatic resync();
        while (sb.phase != PH_WAIT)
            send_link(8'($urandom_range(255)), $urandom_range(3) == 0);
    endtask

    // Mostly good frames with random content, the rest broken frames and noise.
    task automatic random_segment(int unsigned target);
        int unsigned start;
        int unsigned pick;
        int unsigned hsize;
        logic [31:0] len;
        logic [7:0]  v;
        start = link_items;
        while (link_items - start < target)
        begin
            hsize = (sb.fmt == FMT_FMT) ? HDR_SHORT : HDR_LONG;
            pick = $urandom_range(99);
            if (pick < 70)
                send_frame(random_payload_len(), END_FLAG);
            else if (pick < 78)
            begin
                do
                    v = 8'($urandom_range(255));
                while (v == START_FLAG);
                send_byte(v);
            end
            else if (pick < 86)
            begin
                do
                    v = 8'($urandom_range(255));
                while (v == END_FLAG);
                send_frame(random_payload_len(), v);
            end
            else if (pick < 93 || sb.fmt != FMT_MULTI)
            begin
                send_byte(START_FLAG);
                send_header($urandom_range(hsize - 1));
            end
            else
            begin
                // Payload just over one chunk, or anything up to the 32-bit limit.
                if ($urandom_range(1) == 0)
                    len = HDR_LONG + CHUNK_BYTES + 1;
                else
                begin
                    len = $urandom;
                    if (len <= HDR_LONG + CHUNK_BYTES)
                        len = len + HDR_LONG + CHUNK_BYTES + 1;
                end
                send_byte(START_FLAG);
                send_header(len);
            end
            resync();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = ADDR_FRAME_FORMAT;
        pwdata = 32'd0;
        link_valid = 1'b0;
        link_data = '0;
        link_items = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_len = 0;
        hold_go = 1'b0;
        sb = new();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // The format register comes out of reset as the 3-byte header format.
        apb_access(1'b0, {30'd0, FMT_FMT});

        // Short header: one payload byte, frame spanning a buffer boundary.
        send_link(START_FLAG, 1'b0);
        send_link(8'h04, 1'b0);
        send_link(8'h00, 1'b0);
        send_link(8'h00, 1'b1);
        send_link(8'hFF, 1'b0);
        send_link(END_FLAG, 1'b0);
        // Bad start on the last byte of a buffer.
        send_link(8'h00, 1'b1);
        // Length below the header size, then a start flag dropped with the buffer.
        send_link(START_FLAG, 1'b0);
        send_link(8'h02, 1'b0);
        send_link(8'h00, 1'b0);
        send_link(8'hAA, 1'b0);
        send_link(START_FLAG, 1'b1);
        // Zero payload: end flag right after the header.
        send_link(START_FLAG, 1'b0);
        send_link(8'h03, 1'b0);
        send_link(8'h00, 1'b0);
        send_link(8'h55, 1'b0);
        send_link(END_FLAG, 1'b0);
        drain_results();

        // Rfs: header passed on as payload, then a bad end flag.
        write_format(FMT_RFS);
        send_link(START_FLAG, 1'b0);
        send_link(8'h07, 1'b0);
        send_link(8'h00, 1'b0);
        send_link(8'h00, 1'b0);
        send_link(8'h00, 1'b0);
        send_link(8'hFF, 1'b0);
        send_link(8'h80, 1'b0);
        send_link(8'h5A, 1'b0);
        send_link(8'h00, 1'b1);
        // Format change in the middle of a header.
        send_link(START_FLAG, 1'b0);
        send_link(8'h02, 1'b0);
        send_link(8'h00, 1'b0);
        drain_results();
        write_format(FMT_FMT);
        send_link(8'h11, 1'b1);

        // Random phases over every format and every idling mode.
        for (int seg = 0; seg < 8; seg++)
        begin
            drain_results();
            case (seg / 2)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 85;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 85;
                end
                default:
                begin
                    send_idle_pct = 14;
                    stall_pct = 14;
                end
            endcase
            write_format(seg[1:0]);
            // Long receiver hold-off while the sender keeps offering beats.
            if (seg == 4)
            begin
                hold_len = HOLD_CYCLES;
                hold_go = ~hold_go;
                send_frame(64, END_FLAG);
            end
            random_segment(SEGMENT_ITEMS);
        end

        drain_results();
        $display("Run covered %0d link beats over all four frame formats and idling modes.",
                 sb.beats_seen);
        $display("Results: %0d payload bytes, %0d chunk ends, %0d frames done, %0d errors.",
                 sb.payload_seen, sb.chunk_ends_seen, sb.frames_done, sb.frame_errors);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
